// File: hw/rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared definitions for the bus master
// Register map, phase and status codes, opcodes and the register bundle.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Register file geometry
    localparam int REG_W          = 10;
    localparam int NUM_REGS       = 8;
    localparam int REG_IDX_W      = 3;
    localparam int PADDR_W        = REG_IDX_W + 2;
    localparam int PDATA_W        = 32;
    localparam int COUNT_BITS_DEF = 10;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_HOLD   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EARLY_LOW    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRES_WAIT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRES_RELEASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_HOLD    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_RECOV   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT   = 3'd7;

    // Reset values, in register index order
    localparam logic [REG_W-1:0] REG_DEFAULTS [NUM_REGS] = '{
        10'd550, 10'd10, 10'd60, 10'd300, 10'd1, 10'd10, 10'd45, 10'd60
    };

    // Opcodes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    // Phase codes
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PH_W-1:0] PH_R_HOLD    = 4'd1;
    localparam logic [PH_W-1:0] PH_R_EARLY   = 4'd2;
    localparam logic [PH_W-1:0] PH_R_PRES    = 4'd3;
    localparam logic [PH_W-1:0] PH_R_REL     = 4'd4;
    localparam logic [PH_W-1:0] PH_RD_HOLD   = 4'd5;
    localparam logic [PH_W-1:0] PH_RD_SAMPLE = 4'd6;
    localparam logic [PH_W-1:0] PH_RD_REC    = 4'd7;
    localparam logic [PH_W-1:0] PH_WR_HOLD   = 4'd8;
    localparam logic [PH_W-1:0] PH_WR_SLOT   = 4'd9;

    // Status codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_PRESENCE     = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_PRESENCE  = 3'd1;
    localparam logic [ST_W-1:0] ST_STUCK_HIGH   = 3'd2;
    localparam logic [ST_W-1:0] ST_EARLY_LOW    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_RELEASED = 3'd4;
    localparam logic [ST_W-1:0] ST_SLOT_OK      = 3'd5;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [REG_W-1:0] reset_hold;
        logic [REG_W-1:0] early_low;
        logic [REG_W-1:0] pres_wait;
        logic [REG_W-1:0] pres_release;
        logic [REG_W-1:0] slot_hold;
        logic [REG_W-1:0] read_sample;
        logic [REG_W-1:0] read_recov;
        logic [REG_W-1:0] write_slot;
    } owm_cfg_t;

endpackage

// File: hw/rtl/owm_if.sv
// ----------------------------------------------------------------------------
// owm_tick_if / owm_res_if: tick and result channels
// Valid/ready channels carrying one bus tick in and one result out.
// ----------------------------------------------------------------------------
interface owm_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       write_value;
    logic       line_level;

    modport source (output valid, output opcode, output write_value, output line_level,
                    input ready);
    modport sink   (input valid, input opcode, input write_value, input line_level,
                    output ready);
endinterface

interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic       read_bit;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output read_bit, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input read_bit, output ready);
endinterface

// File: hw/rtl/owm_regs.sv
// ----------------------------------------------------------------------------
// owm_regs: APB register file
// Eight 10-bit timing registers, written and read over APB, zero wait.
// ----------------------------------------------------------------------------
module owm_regs
    import owm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output owm_cfg_t           cfg
);

    logic [REG_W-1:0]     regs_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = PDATA_W'(regs_reg[idx]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= REG_DEFAULTS[i];
            end
        end
        else if (wr_en)
        begin
            regs_reg[idx] <= pwdata[REG_W-1:0];
        end
    end

    // Bundle for the sequencer
    assign cfg.reset_hold   = regs_reg[REG_RESET_HOLD];
    assign cfg.early_low    = regs_reg[REG_EARLY_LOW];
    assign cfg.pres_wait    = regs_reg[REG_PRES_WAIT];
    assign cfg.pres_release = regs_reg[REG_PRES_RELEASE];
    assign cfg.slot_hold    = regs_reg[REG_SLOT_HOLD];
    assign cfg.read_sample  = regs_reg[REG_READ_SAMPLE];
    assign cfg.read_recov   = regs_reg[REG_READ_RECOV];
    assign cfg.write_slot   = regs_reg[REG_WRITE_SLOT];

endmodule

// File: hw/rtl/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core: tick sequencer
// Input register, one pass of phase logic, result register.
// ----------------------------------------------------------------------------
module owm_core
    import owm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  owm_cfg_t cfg,
    owm_tick_if.sink tick,
    owm_res_if.source result
);

    localparam int LW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
    localparam logic [LW-1:0] CNT_MAX = LW'((64'd1 << COUNT_BITS) - 64'd1);

    // Register value clipped to the counter range
    function automatic logic [COUNT_BITS-1:0] lim_f(input logic [REG_W-1:0] r);
        logic [LW-1:0] rx;
        logic [LW-1:0] rs;
        rx = LW'(r);
        rs = (rx > CNT_MAX) ? CNT_MAX : rx;
        return rs[COUNT_BITS-1:0];
    endfunction

    // Input stage
    logic       in_vld_reg;
    logic [1:0] op_reg;
    logic       wv_reg;
    logic       lv_reg;

    // Sequencer state
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_reg, tick_next;
    logic                  bit_reg, bit_next;
    logic                  send_reg, send_next;

    // Result stage
    logic            out_vld_reg;
    logic            drive_reg, drive_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [ST_W-1:0] st_reg, st_next;
    logic            rbit_reg;

    logic            fire;
    logic            in_take;
    logic [COUNT_BITS-1:0] lim_rh, lim_el, lim_pw, lim_pr, lim_sh, lim_rs, lim_rr, lim_ws;
    logic [COUNT_BITS-1:0] tick_inc;

    assign lim_rh = lim_f(cfg.reset_hold);
    assign lim_el = lim_f(cfg.early_low);
    assign lim_pw = lim_f(cfg.pres_wait);
    assign lim_pr = lim_f(cfg.pres_release);
    assign lim_sh = lim_f(cfg.slot_hold);
    assign lim_rs = lim_f(cfg.read_sample);
    assign lim_rr = lim_f(cfg.read_recov);
    assign lim_ws = lim_f(cfg.write_slot);
    assign tick_inc = tick_reg + 1'b1;

    // Handshakes: stage 1 moves on when the result slot is free or draining
    assign fire        = in_vld_reg & (~out_vld_reg | result.ready);
    assign in_take     = tick.valid & tick.ready;
    assign tick.ready  = ~in_vld_reg | fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_vld_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= tick.opcode;
            wv_reg <= tick.write_value;
            lv_reg <= tick.line_level;
        end
    end

    // Phase logic for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        send_next  = send_reg;
        drive_next = 1'b0;
        busy_next  = 1'b1;
        done_next  = 1'b0;
        st_next    = ST_PRESENCE;

        case (phase_reg)
            PH_R_HOLD:
            begin
                if (lv_reg)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = ST_STUCK_HIGH;
                end
                else if (tick_reg >= lim_rh)
                begin
                    phase_next = PH_R_EARLY;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next  = tick_inc;
                    drive_next = 1'b1;
                end
            end
            PH_R_EARLY:
            begin
                if (!lv_reg)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = ST_EARLY_LOW;
                end
                else if (tick_reg >= lim_el)
                begin
                    phase_next = PH_R_PRES;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_R_PRES:
            begin
                if (!lv_reg)
                begin
                    phase_next = PH_R_REL;
                    tick_next  = '0;
                end
                else if (tick_reg >= lim_pw)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = ST_NO_PRESENCE;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_R_REL:
            begin
                if (lv_reg || tick_reg >= lim_pr)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = lv_reg ? ST_PRESENCE : ST_NOT_RELEASED;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RD_HOLD, PH_WR_HOLD:
            begin
                if (lv_reg)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = ST_STUCK_HIGH;
                end
                else if (tick_reg >= lim_sh)
                begin
                    tick_next = '0;
                    if (phase_reg == PH_RD_HOLD)
                    begin
                        phase_next = PH_RD_SAMPLE;
                    end
                    else if (lim_ws == '0)
                    begin
                        phase_next = PH_IDLE;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                        st_next    = ST_SLOT_OK;
                    end
                    else
                    begin
                        phase_next = PH_WR_SLOT;
                        drive_next = ~send_reg;
                    end
                end
                else
                begin
                    tick_next  = tick_inc;
                    drive_next = 1'b1;
                end
            end
            PH_RD_SAMPLE:
            begin
                if (lv_reg || tick_reg >= lim_rs)
                begin
                    bit_next  = lv_reg;
                    tick_next = '0;
                    if (lim_rr == '0)
                    begin
                        phase_next = PH_IDLE;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                        st_next    = ST_SLOT_OK;
                    end
                    else
                    begin
                        phase_next = PH_RD_REC;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RD_REC, PH_WR_SLOT:
            begin
                tick_next = tick_inc;
                if (tick_inc >= ((phase_reg == PH_RD_REC) ? lim_rr : lim_ws))
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    st_next    = ST_SLOT_OK;
                end
                else if (phase_reg == PH_WR_SLOT)
                begin
                    drive_next = ~send_reg;
                end
            end
            default:
            begin
                // Idle, and any unused code falls back to idle
                phase_next = PH_IDLE;
                tick_next  = '0;
                busy_next  = 1'b0;
                case (op_reg)
                    OP_RESET: phase_next = PH_R_HOLD;
                    OP_READ:  phase_next = PH_RD_HOLD;
                    OP_WRITE:
                    begin
                        phase_next = PH_WR_HOLD;
                        send_next  = wv_reg;
                    end
                    default:  phase_next = PH_IDLE;
                endcase
                if (op_reg != OP_NONE)
                begin
                    drive_next = 1'b1;
                    busy_next  = 1'b1;
                end
            end
        endcase
    end

    // Sequencer state, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= 1'b0;
            send_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            send_reg  <= send_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg <= drive_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            st_reg    <= st_next;
            rbit_reg  <= bit_next;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.drive_low = drive_reg;
    assign result.busy_res  = busy_reg;
    assign result.done_res  = done_reg;
    assign result.status    = st_reg;
    assign result.read_bit  = rbit_reg;

endmodule

// File: hw/rtl/one_wire_master_slots.sv
// ----------------------------------------------------------------------------
// one_wire_master_slots: tick-driven single-wire bus master
// Runs reset/presence, read slot and write slot sequences one tick per beat.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake      Beat contents
// tick      in    valid/ready    opcode, write_value, line_level
// result    out   valid/ready    drive_low, busy_res, done_res, status, read_bit
// apb       in    psel/penable   eight 10-bit timing registers at 4*i
//
// One beat in gives one beat out. A tick beat is registered, decoded against
// the phase state in one pass and lands in the result register, so a new tick
// is taken every cycle while the result is not stalled; the result is valid once
// the beat has moved from the input register into the result register.
// A stalled result holds the result register and the input register fills
// behind it. Reset clears both stages and the phase state and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module one_wire_master_slots
    import owm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    owm_tick_if.sink           tick,
    owm_res_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    owm_cfg_t cfg;

    owm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .result (result)
    );

endmodule
